>>> rtl/fcch_pkg.sv
package fcch_pkg;

  // filter dimensions
  localparam int unsigned MAX_TAPS     = 64;
  localparam int unsigned ADDR_W       = 6;
  localparam int unsigned TAP_W        = 7;
  localparam int unsigned SAMPLE_W     = 16;
  localparam int unsigned ACC_W        = 32;
  localparam int unsigned RESULT_SHIFT = 16;

  // item operation codes
  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_LOAD   = 1'b1
  } op_e;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_WAIT,
    ST_FINISH
  } state_e;

  // control word that travels down the multiply-accumulate pipe
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } mac_ctrl_t;

  // tap count as used: zero acts as one, anything above the maximum is clamped
  function automatic logic [TAP_W-1:0] eff_taps(input logic [TAP_W-1:0] taps);
    logic [TAP_W-1:0] res;
    if (taps == '0) begin
      res = TAP_W'(1);
    end else if (taps > TAP_W'(MAX_TAPS)) begin
      res = TAP_W'(MAX_TAPS);
    end else begin
      res = taps;
    end
    return res;
  endfunction

endpackage

>>> rtl/fcch_if.sv
// input word channel
interface fcch_in_if;
  logic                                valid;
  logic                                ready;
  logic                                operation;
  logic signed [fcch_pkg::SAMPLE_W-1:0] sample;
  logic        [fcch_pkg::ADDR_W-1:0]   coef_index;
  logic signed [fcch_pkg::SAMPLE_W-1:0] coef_value;

  modport source (output valid, output operation, output sample, output coef_index,
                  output coef_value, input ready);
  modport sink   (input valid, input operation, input sample, input coef_index,
                  input coef_value, output ready);
endinterface

// result word channel
interface fcch_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [fcch_pkg::SAMPLE_W-1:0] filtered;

  modport source (output valid, output filtered, input ready);
  modport sink   (input valid, input filtered, output ready);
endinterface

// tap count register write channel
interface fcch_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [fcch_pkg::TAP_W-1:0]      taps_in_use;

  modport source (output valid, output taps_in_use, input ready);
  modport sink   (input valid, input taps_in_use, output ready);
endinterface

>>> rtl/fir_filter_circular_history.sv
// FIR filter, one shared multiplier stepping over the taps newest sample first.
// A sample word is written to the history, stepped over the taps (tap count clamped
// to 1..64) and its result loaded into the output register once that is free; the
// next word is taken only after the result is registered, so no new sample enters
// while one is in flight. A coefficient load word is written and gives no result.
// Reset is asynchronous, active low: history and coefficients read as zero, write
// position zero, tap count 64.
module fir_filter_circular_history (
  input  logic      clk_i,
  input  logic      rst_ni,
  fcch_in_if.sink   in_i,
  fcch_cfg_if.sink  cfg_i,
  fcch_out_if.source out_o
);
  import fcch_pkg::*;

  logic                       hist_we;
  logic [ADDR_W-1:0]          hist_waddr;
  logic [ADDR_W-1:0]          hist_raddr;
  logic                       coef_we;
  logic [ADDR_W-1:0]          coef_raddr;
  logic signed [SAMPLE_W-1:0] hist_rdata;
  logic signed [SAMPLE_W-1:0] coef_rdata;
  mac_ctrl_t                  mac_ctrl;
  logic [ACC_W-1:0]           acc;
  logic                       mac_done;
  logic                       out_free;
  logic                       out_load;
  logic                       out_vld_q;
  logic signed [SAMPLE_W-1:0] out_q;

  // sequencer
  fcch_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .cfg_i        (cfg_i),
    .hist_we_o    (hist_we),
    .hist_waddr_o (hist_waddr),
    .hist_raddr_o (hist_raddr),
    .coef_we_o    (coef_we),
    .coef_raddr_o (coef_raddr),
    .mac_o        (mac_ctrl),
    .mac_done_i   (mac_done),
    .out_free_i   (out_free),
    .out_load_o   (out_load)
  );

  // circular sample history
  fcch_store u_hist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (hist_we),
    .waddr_i (hist_waddr),
    .wdata_i (in_i.sample),
    .raddr_i (hist_raddr),
    .rdata_o (hist_rdata)
  );

  // coefficient store
  fcch_store u_coef (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (coef_we),
    .waddr_i (in_i.coef_index),
    .wdata_i (in_i.coef_value),
    .raddr_i (coef_raddr),
    .rdata_o (coef_rdata)
  );

  // shared multiply-accumulate unit
  fcch_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mac_ctrl),
    .hist_i (hist_rdata),
    .coef_i (coef_rdata),
    .acc_o  (acc),
    .done_o (mac_done)
  );

  // output word register
  assign out_free = !out_vld_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= acc[RESULT_SHIFT +: SAMPLE_W];
    end
  end

  assign out_o.valid    = out_vld_q;
  assign out_o.filtered = out_q;

endmodule

>>> rtl/fcch_store.sv
module fcch_store (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                we_i,
  input  logic        [fcch_pkg::ADDR_W-1:0]   waddr_i,
  input  logic signed [fcch_pkg::SAMPLE_W-1:0] wdata_i,
  input  logic        [fcch_pkg::ADDR_W-1:0]   raddr_i,
  output logic signed [fcch_pkg::SAMPLE_W-1:0] rdata_o
);
  import fcch_pkg::*;

  logic signed [SAMPLE_W-1:0] mem [MAX_TAPS];
  logic [MAX_TAPS-1:0]        vld_q;
  logic signed [SAMPLE_W-1:0] rdata_q;
  logic                       rvld_q;

  // entry valid bits, cleared at reset so unwritten entries read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (we_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
      rvld_q <= vld_q[raddr_i];
    end
  end

  // storage array, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rvld_q ? rdata_q : '0;

endmodule

>>> rtl/fcch_mac.sv
module fcch_mac (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  fcch_pkg::mac_ctrl_t                  ctrl_i,
  input  logic signed [fcch_pkg::SAMPLE_W-1:0] hist_i,
  input  logic signed [fcch_pkg::SAMPLE_W-1:0] coef_i,
  output logic        [fcch_pkg::ACC_W-1:0]    acc_o,
  output logic                                done_o
);
  import fcch_pkg::*;

  mac_ctrl_t          s1_q, s2_q;
  logic signed [ACC_W-1:0] prod_q;
  logic [ACC_W-1:0]   acc_q;
  logic               done_q;

  // control alignment with read data and product
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q   <= '0;
      s2_q   <= '0;
      done_q <= 1'b0;
    end else begin
      s1_q   <= ctrl_i;
      s2_q   <= s1_q;
      done_q <= s2_q.valid && s2_q.last;
    end
  end

  // shared multiplier and accumulator, sum wraps at 32 bits
  always_ff @(posedge clk_i) begin
    prod_q <= ACC_W'(hist_i * coef_i);
    if (s2_q.valid) begin
      if (s2_q.first) begin
        acc_q <= prod_q;
      end else begin
        acc_q <= acc_q + prod_q;
      end
    end
  end

  assign acc_o  = acc_q;
  assign done_o = done_q;

endmodule

>>> rtl/fcch_ctrl.sv
module fcch_ctrl (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  fcch_in_if.sink                             in_i,
  fcch_cfg_if.sink                            cfg_i,
  output logic                                hist_we_o,
  output logic        [fcch_pkg::ADDR_W-1:0]   hist_waddr_o,
  output logic        [fcch_pkg::ADDR_W-1:0]   hist_raddr_o,
  output logic                                coef_we_o,
  output logic        [fcch_pkg::ADDR_W-1:0]   coef_raddr_o,
  output fcch_pkg::mac_ctrl_t                  mac_o,
  input  logic                                mac_done_i,
  input  logic                                out_free_i,
  output logic                                out_load_o
);
  import fcch_pkg::*;

  state_e            state_q, state_d;
  logic [TAP_W-1:0]  taps_q;
  logic [TAP_W-1:0]  eff_q, eff_d;
  logic [ADDR_W-1:0] wp_q, wp_d;
  logic [ADDR_W-1:0] pos_q, pos_d;
  logic [ADDR_W-1:0] cnt_q, cnt_d;
  logic [TAP_W-1:0]  eff_now;
  logic [ADDR_W-1:0] wp_cur;
  logic [TAP_W-1:0]  wp_inc;
  logic [ADDR_W-1:0] wp_nxt;
  logic [ADDR_W-1:0] eff_last;
  logic              accept;
  logic              last_tap;

  // tap count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      taps_q <= TAP_W'(MAX_TAPS);
    end else if (cfg_i.valid) begin
      taps_q <= cfg_i.taps_in_use;
    end
  end
  assign cfg_i.ready = 1'b1;

  // write position with wrap, also covers a stale position after a tap change
  assign eff_now  = eff_taps(taps_q);
  assign wp_cur   = ({1'b0, wp_q} >= eff_now) ? '0 : wp_q;
  assign wp_inc   = {1'b0, wp_cur} + TAP_W'(1);
  assign wp_nxt   = (wp_inc >= eff_now) ? '0 : wp_inc[ADDR_W-1:0];
  assign eff_last = ADDR_W'(eff_q - TAP_W'(1));
  assign last_tap = (cnt_q == eff_last);

  assign in_i.ready = (state_q == ST_IDLE);
  assign accept     = in_i.valid && (state_q == ST_IDLE);

  // state and loop registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      wp_q    <= '0;
      eff_q   <= TAP_W'(1);
      pos_q   <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      wp_q    <= wp_d;
      eff_q   <= eff_d;
      pos_q   <= pos_d;
      cnt_q   <= cnt_d;
    end
  end

  // sequencer: next state and outputs
  always_comb begin
    state_d    = state_q;
    wp_d       = wp_q;
    eff_d      = eff_q;
    pos_d      = pos_q;
    cnt_d      = cnt_q;
    hist_we_o  = 1'b0;
    coef_we_o  = 1'b0;
    mac_o      = '0;
    out_load_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (op_e'(in_i.operation) == OP_LOAD) begin
            coef_we_o = 1'b1;
          end else begin
            hist_we_o = 1'b1;
            wp_d      = wp_nxt;
            pos_d     = wp_cur;
            cnt_d     = '0;
            eff_d     = eff_now;
            state_d   = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        mac_o.valid = 1'b1;
        mac_o.first = (cnt_q == '0);
        mac_o.last  = last_tap;
        cnt_d       = cnt_q + ADDR_W'(1);
        pos_d       = (pos_q == '0) ? eff_last : pos_q - ADDR_W'(1);
        if (last_tap) begin
          state_d = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (mac_done_i) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free_i) begin
          out_load_o = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign hist_waddr_o = wp_cur;
  assign hist_raddr_o = pos_q;
  assign coef_raddr_o = cnt_q;

endmodule
